>>> sv/vdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared constants, types and functions of the vertex deduplicating indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int KEEP_W      = 5;
    localparam int OUT_IDX_W   = 10;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(FRAC_BITS);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COORD_W-1:0] coord_t;

    // controller -> datapath
    typedef struct packed {
        logic init_step;  // zero one hash slot after reset
        logic load;       // latch quantized vertex, reset probe
        logic clear;      // empty the table, issue zero result
        logic next_probe; // step to the next hash slot
        logic insert;     // store vertex under next index
        logic res_hit;    // issue hit result
        logic res_full;   // issue table full result
    } vdi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic init_last;
        logic hit;
        logic live;
        logic full;
        logic probe_last;
    } vdi_stat_t;

    // truncate Q15.16 toward zero keeping 'keep' fraction bits
    function automatic coord_t quantize(input coord_t v, input logic [KEEP_W-1:0] keep);
        coord_t mask;
        coord_t mag;
        coord_t res;
        begin
            mask = '0;
            res  = v;
            if (keep < KEEP_W'(FRAC_BITS)) begin
                mask = (coord_t'(1) << (KEEP_W'(FRAC_BITS) - keep)) - coord_t'(1);
                if (v[COORD_W-1]) begin
                    mag = (~v + coord_t'(1)) & ~mask;
                    res = ~mag + coord_t'(1);
                end
                else begin
                    res = v & ~mask;
                end
            end
            return res;
        end
    endfunction

    // xor fold of the key into a slot number
    function automatic idx_t hash_key(input coord_t x, input coord_t y, input coord_t z);
        logic [3*COORD_W-1:0] k;
        idx_t h;
        begin
            k = {x, y, z};
            h = '0;
            for (int i = 0; i < 3*COORD_W; i++) begin
                h[i % IDX_W] = h[i % IDX_W] ^ k[i];
            end
            return h;
        end
    endfunction

endpackage

>>> sv/vdi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_ctrl
// Sequencer for the post-reset table clear, clear commands and the probe loop: hash read, key read, compare.
// ----------------------------------------------------------------------------
module vdi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cmd,
    input  vdi_pkg::vdi_stat_t stat,
    output vdi_pkg::vdi_cmd_t  ctl,
    output logic              busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HRD  = 3'd1;
    localparam logic [2:0] S_KRD  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_INIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.init_step = 1'b1;
                if (stat.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start) begin
                    if (cmd) begin
                        ctl.clear = 1'b1;
                    end
                    else begin
                        ctl.load   = 1'b1;
                        state_next = S_HRD;
                    end
                end
            end
            S_HRD: state_next = S_KRD;
            S_KRD: state_next = S_CMP;
            S_CMP:
            begin
                if (stat.live && stat.hit) begin
                    ctl.res_hit = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!stat.live) begin
                    if (stat.full) begin
                        ctl.res_full = 1'b1;
                    end
                    else begin
                        ctl.insert = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (stat.probe_last) begin
                    // every slot holds another vertex
                    ctl.res_full = 1'b1;
                    state_next   = S_IDLE;
                end
                else begin
                    ctl.next_probe = 1'b1;
                    state_next     = S_HRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_INIT;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> sv/vdi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_datapath
// Quantizer, hash slot table, vertex key table and result registers.
// ----------------------------------------------------------------------------
module vdi_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vdi_pkg::vdi_cmd_t                 ctl,
    output vdi_pkg::vdi_stat_t                stat,
    input  logic                              cfg_write,
    input  logic [vdi_pkg::KEEP_W-1:0]        cfg_data,
    input  logic [vdi_pkg::COORD_W-1:0]       coord_x,
    input  logic [vdi_pkg::COORD_W-1:0]       coord_y,
    input  logic [vdi_pkg::COORD_W-1:0]       coord_z,
    output logic                              done,
    output logic [vdi_pkg::OUT_IDX_W-1:0]     vertex_index,
    output logic                              was_new,
    output logic                              table_full,
    output logic [vdi_pkg::COORD_W-1:0]       quant_x,
    output logic [vdi_pkg::COORD_W-1:0]       quant_y,
    output logic [vdi_pkg::COORD_W-1:0]       quant_z
);

    localparam int KEY_W = 3*vdi_pkg::COORD_W + vdi_pkg::IDX_W;

    logic [vdi_pkg::KEEP_W-1:0] keep_reg;
    vdi_pkg::coord_t qx_reg, qy_reg, qz_reg;
    vdi_pkg::idx_t   h_reg;
    vdi_pkg::idx_t   probe_reg;
    vdi_pkg::cnt_t   count_reg;
    vdi_pkg::idx_t   init_ptr_reg;

    // hash slot -> vertex index; vertex index -> {key, owning slot}
    vdi_pkg::idx_t    hash_mem [vdi_pkg::TABLE_DEPTH];
    logic [KEY_W-1:0] key_mem  [vdi_pkg::TABLE_DEPTH];
    vdi_pkg::idx_t    hash_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;

    logic             done_reg;
    vdi_pkg::idx_t    idx_out_reg;
    logic             new_reg, full_reg;
    vdi_pkg::coord_t  ox_reg, oy_reg, oz_reg;

    vdi_pkg::coord_t  qx, qy, qz;
    vdi_pkg::coord_t  kx, ky, kz;
    vdi_pkg::idx_t    kslot;
    logic             any_res;

    assign qx = vdi_pkg::quantize(coord_x, keep_reg);
    assign qy = vdi_pkg::quantize(coord_y, keep_reg);
    assign qz = vdi_pkg::quantize(coord_z, keep_reg);
    assign {kx, ky, kz, kslot} = key_rd_reg;

    // a slot is live only if its index is in use and points back to it
    assign stat.live = (vdi_pkg::cnt_t'(hash_rd_reg) < count_reg) && (kslot == h_reg);
    assign stat.hit  = (kx == qx_reg) && (ky == qy_reg) && (kz == qz_reg);
    assign stat.full = (count_reg == vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH));
    assign stat.probe_last = (probe_reg == '1);
    assign stat.init_last  = (init_ptr_reg == '1);

    assign any_res = ctl.clear || ctl.res_hit || ctl.res_full || ctl.insert;

    always_ff @(posedge clk)
    begin
        hash_rd_reg <= hash_mem[h_reg];
        key_rd_reg  <= key_mem[hash_rd_reg];
        if (ctl.insert) begin
            hash_mem[h_reg] <= count_reg[vdi_pkg::IDX_W-1:0];
            key_mem[count_reg[vdi_pkg::IDX_W-1:0]] <= {qx_reg, qy_reg, qz_reg, h_reg};
        end
        else if (ctl.init_step) begin
            hash_mem[init_ptr_reg] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load) begin
            qx_reg    <= qx;
            qy_reg    <= qy;
            qz_reg    <= qz;
            h_reg     <= vdi_pkg::hash_key(qx, qy, qz);
            probe_reg <= '0;
        end
        else if (ctl.next_probe) begin
            h_reg     <= h_reg + vdi_pkg::idx_t'(1);
            probe_reg <= probe_reg + vdi_pkg::idx_t'(1);
        end
        if (any_res) begin
            idx_out_reg <= ctl.res_hit ? hash_rd_reg :
                           ctl.insert  ? count_reg[vdi_pkg::IDX_W-1:0] : '0;
            new_reg     <= ctl.insert;
            full_reg    <= ctl.res_full;
            ox_reg      <= ctl.clear ? '0 : qx_reg;
            oy_reg      <= ctl.clear ? '0 : qy_reg;
            oz_reg      <= ctl.clear ? '0 : qz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            keep_reg     <= vdi_pkg::KEEP_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            init_ptr_reg <= '0;
        end
        else begin
            if (cfg_write) begin
                keep_reg <= cfg_data;
            end
            if (ctl.clear) begin
                count_reg <= '0;
            end
            else if (ctl.insert) begin
                count_reg <= count_reg + vdi_pkg::cnt_t'(1);
            end
            if (ctl.init_step) begin
                init_ptr_reg <= init_ptr_reg + vdi_pkg::idx_t'(1);
            end
            done_reg <= any_res;
        end
    end

    assign done         = done_reg;
    assign vertex_index = vdi_pkg::OUT_IDX_W'(idx_out_reg);
    assign was_new      = new_reg;
    assign table_full   = full_reg;
    assign quant_x      = ox_reg;
    assign quant_y      = oy_reg;
    assign quant_z      = oz_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH))
        else $error("stored count beyond table depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |-> !stat.full)
        else $error("insert into full table");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (count_reg == '0) && done_reg && !was_new && !table_full)
        else $error("clear did not empty table");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(was_new && table_full))
        else $error("new and full flagged together");

endmodule

>>> sv/vertex_dedup_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Quantizes a vertex and returns its index in a table of unique vertices.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. A clear gives its
// result in the next cycle. An add makes one pass per probe of the hash slot
// table (slot read, key read, compare), then registers the result; more
// probes follow under collisions, up to 1024 when every slot holds another
// vertex. The result appears for one cycle with done high and must be taken
// then; the receiver cannot stall. After reset busy stays high while the
// hash slot table is cleared.
module vertex_dedup_indexer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [vdi_pkg::COORD_W-1:0]   coord_x,
    input  logic [vdi_pkg::COORD_W-1:0]   coord_y,
    input  logic [vdi_pkg::COORD_W-1:0]   coord_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vdi_pkg::KEEP_W-1:0]    cfg_data,
    output logic                          done,
    output logic [vdi_pkg::OUT_IDX_W-1:0] vertex_index,
    output logic                          was_new,
    output logic                          table_full,
    output logic [vdi_pkg::COORD_W-1:0]   quant_x,
    output logic [vdi_pkg::COORD_W-1:0]   quant_y,
    output logic [vdi_pkg::COORD_W-1:0]   quant_z
);

    vdi_pkg::vdi_cmd_t  ctl;
    vdi_pkg::vdi_stat_t stat;

    assign cfg_ready = 1'b1;

    vdi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    vdi_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .done         (done),
        .vertex_index (vertex_index),
        .was_new      (was_new),
        .table_full   (table_full),
        .quant_x      (quant_x),
        .quant_y      (quant_y),
        .quant_z      (quant_z)
    );

endmodule
